// ===== hw/rtl/zbtr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbtr_pkg
// Shared types and constants of the z-buffer triangle rasterizer.
// ----------------------------------------------------------------------------
package zbtr_pkg;

  localparam int DEF_CANVAS_WIDTH  = 64;
  localparam int DEF_CANVAS_HEIGHT = 64;

  localparam int CW = 16;  // coordinate width, Q12.4
  localparam int ZW = 24;  // depth width
  localparam int VW = 26;  // interpolated value width
  localparam int NW = 17;  // numerator and divisor width
  localparam int PW = 42;  // product width
  localparam int KW = 13;  // pixel count width

  localparam logic [ZW-1:0] DEPTH_MAX = {ZW{1'b1}};
  localparam logic [KW-1:0] COUNT_MAX = {KW{1'b1}};

  localparam logic [1:0] KIND_DRAW  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic REG_BG_COLOR    = 1'b0;
  localparam logic REG_CLEAR_DEPTH = 1'b1;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ZW-1:0]        z;
  } vtx_t;

  typedef struct packed {
    logic signed [VW-1:0] a;
    logic signed [VW-1:0] b;
    logic [NW-1:0]        num;
    logic [NW-1:0]        den;
  } lerp_req_t;

endpackage

// ===== hw/rtl/zbtr_lerp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbtr_lerp
// Shared interpolation unit: a + floor((b - a) * num / den), den > 0,
// by a shift-add multiply and a restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module zbtr_lerp import zbtr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  lerp_req_t            req,
  output logic                 busy,
  output logic                 done,
  output logic signed [VW-1:0] result
);

  typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV, L_FIX} lstate_t;

  lstate_t              state;
  logic signed [VW-1:0] base;
  logic                 neg;
  logic [PW-1:0]        mag;
  logic [NW-1:0]        mul_src;
  logic [PW-1:0]        prod;
  logic [NW-1:0]        rem;
  logic [NW-1:0]        den;
  logic [5:0]           cnt;

  logic signed [VW:0]   diff;
  logic [VW:0]          diff_abs;
  logic [NW:0]          trial;
  logic                 fits;
  logic signed [VW:0]   quot;
  logic signed [VW:0]   adj;
  logic signed [VW:0]   sum;

  assign busy = (state != L_IDLE);

  always_comb begin
    diff     = (VW+1)'(req.b) - (VW+1)'(req.a);
    diff_abs = diff[VW] ? (VW+1)'(-diff) : (VW+1)'(diff);
    trial    = {rem, prod[PW-1]};
    fits     = (trial >= {1'b0, den});
    quot     = (VW+1)'(prod[VW-1:0]);
    adj      = neg ? -(quot + (VW+1)'(rem != '0)) : quot;
    sum      = (VW+1)'(base) + adj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (start) begin
            base    <= req.a;
            neg     <= diff[VW];
            mag     <= PW'(diff_abs);
            mul_src <= req.num;
            den     <= req.den;
            prod    <= '0;
            cnt     <= '0;
            state   <= L_MUL;
          end
        end
        L_MUL: begin
          if (mul_src[0]) prod <= prod + mag;
          mag     <= mag << 1;
          mul_src <= mul_src >> 1;
          cnt     <= cnt + 6'd1;
          if (cnt == 6'(NW-1)) begin
            cnt   <= '0;
            rem   <= '0;
            state <= L_DIV;
          end
        end
        L_DIV: begin
          rem  <= fits ? NW'(trial - {1'b0, den}) : trial[NW-1:0];
          prod <= {prod[PW-2:0], fits};
          cnt  <= cnt + 6'd1;
          if (cnt == 6'(PW-1)) state <= L_FIX;
        end
        L_FIX: begin
          result <= sum[VW-1:0];
          done   <= 1'b1;
          state  <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("unit not busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == L_DIV) |-> (rem < den))
    else $error("remainder not below divisor");

endmodule

// ===== hw/rtl/zbuffer_triangle_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbuffer_triangle_rasterizer
// Flat triangle fill into a color and depth store with a strict depth test.
//
// An item enters on in_valid/in_ready and gives one result item on
// out_valid/out_ready. kind selects draw, clear or read. The user must write
// the clear color and clear_depth registers on cfg_we only while the block is
// idle; the block itself does not enforce it. One item is worked on at a
// time; in_ready is high only when idle. Every interpolation runs on one
// shared multiply/divide unit: 17 multiply steps, 42 divide steps and a
// fixup. The block returns to idle, with in_ready high, as the result is
// loaded into the output register. While a result waits in the output
// register the block takes one more item, works it, then holds in its last
// state with in_ready low until out_ready frees the register.
// Reset clears the control state and the registers to their reset values;
// the stores hold no defined contents until the first clear item.
// ----------------------------------------------------------------------------
module zbuffer_triangle_rasterizer import zbtr_pkg::*; #(
  parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
  parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  logic signed [CW-1:0] x1,
  input  logic signed [CW-1:0] y1,
  input  logic [ZW-1:0]        z1,
  input  logic signed [CW-1:0] x2,
  input  logic signed [CW-1:0] y2,
  input  logic [ZW-1:0]        z2,
  input  logic signed [CW-1:0] x3,
  input  logic signed [CW-1:0] y3,
  input  logic [ZW-1:0]        z3,
  input  logic [31:0]          fill_color,
  input  logic [11:0]          pixel_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          read_color,
  output logic [ZW-1:0]        read_depth,
  output logic [KW-1:0]        pixels_written,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int PC = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int AW = $clog2(PC);
  localparam int CB = $clog2(CANVAS_WIDTH);
  localparam int RB = $clog2(CANVAS_HEIGHT);
  localparam int RW = 13;
  localparam logic signed [RW-1:0] COL_LAST = RW'(CANVAS_WIDTH - 1);
  localparam logic signed [RW-1:0] ROW_LAST = RW'(CANVAS_HEIGHT - 1);
  localparam logic [AW-1:0] ADDR_LAST = AW'(PC - 1);
  localparam logic [AW-1:0] ROW_PITCH = AW'(CANVAS_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_RD_A, S_RD_B, S_SETUP, S_ROW_CHK, S_L_START, S_L_WAIT,
    S_ROW_FIX, S_COL_CHK, S_PIX_START, S_PIX_WAIT, S_FINISH
  } state_t;

  state_t               state;
  logic [31:0]          bg_color;
  logic [ZW-1:0]        clear_depth;
  vtx_t                 va, vb, vc;
  logic [31:0]          color;
  logic                 half;
  logic                 lower_en;
  logic signed [RW-1:0] row, lim, r1, lim_lo, col, c1;
  logic [NW-1:0]        d_tot, d_up, d_lo, w;
  logic [1:0]           step;
  logic signed [VW-1:0] ax, az, bx, bz;
  logic [AW-1:0]        addr;
  logic [31:0]          res_color;
  logic [ZW-1:0]        res_depth;
  logic [KW-1:0]        cnt;

  logic [31:0]          color_mem [PC];
  logic [ZW-1:0]        depth_mem [PC];
  logic [31:0]          color_q;
  logic [ZW-1:0]        depth_q;
  logic                 mem_we;
  logic [31:0]          mem_color;
  logic [ZW-1:0]        mem_depth;

  vtx_t                 s0a, s0b, s1a, s1c, s2b, s2c;
  vtx_t                 t1, t2, t3;
  logic signed [CW:0]   tot;
  logic signed [RW-1:0] a_ceil, r0, r1_c, up_lim, lo_ceil, lo_lim;
  logic signed [CW:0]   y_pos;
  logic signed [CW+1:0] num_a, num_b;
  logic signed [VW:0]   x_pos;
  logic signed [VW:0]   num_x;
  logic signed [VW-1:0] lx, lz, rx, rz;
  logic signed [VW:0]   width;
  logic signed [VW:0]   lx_ceil, rx_floor;
  logic signed [RW-1:0] c0_c, c1_c;
  logic [ZW-1:0]        pz;
  logic                 pz_less;
  logic [20:0]          pix_wide;
  logic [AW-1:0]        pix_addr;

  lerp_req_t            req;
  logic                 lerp_start;
  logic                 lerp_busy;
  logic                 lerp_done;
  logic signed [VW-1:0] lerp_res;

  function automatic logic signed [RW-1:0] ceil16(input logic signed [CW-1:0] v);
    logic signed [CW+1:0] t;
    t = (CW+2)'(v) + (CW+2)'(15);
    return RW'(t >>> 4);
  endfunction

  function automatic logic signed [RW-1:0] floor16(input logic signed [CW-1:0] v);
    return RW'(v >>> 4);
  endfunction

  function automatic logic signed [VW-1:0] zext(input logic [ZW-1:0] v);
    return VW'(v);
  endfunction

  assign in_ready = (state == S_IDLE);

  // vertex sort on strictly greater y
  always_comb begin
    t1 = '{x: x1, y: y1, z: z1};
    t2 = '{x: x2, y: y2, z: z2};
    t3 = '{x: x3, y: y3, z: z3};
    s0a = (t1.y > t2.y) ? t2 : t1;
    s0b = (t1.y > t2.y) ? t1 : t2;
    s1a = (s0a.y > t3.y) ? t3 : s0a;
    s1c = (s0a.y > t3.y) ? s0a : t3;
    s2b = (s0b.y > s1c.y) ? s1c : s0b;
    s2c = (s0b.y > s1c.y) ? s0b : s1c;
  end

  always_comb begin
    tot     = (CW+1)'(vc.y) - (CW+1)'(va.y);
    a_ceil  = ceil16(va.y);
    r0      = (a_ceil < 0) ? '0 : a_ceil;
    r1_c    = (floor16(vc.y) > ROW_LAST) ? ROW_LAST : floor16(vc.y);
    up_lim  = (floor16(vb.y) > r1_c) ? r1_c : floor16(vb.y);
    lo_ceil = ceil16(vb.y);
    lo_lim  = (lo_ceil < r0) ? r0 : lo_ceil;

    y_pos = (CW+1)'({row, 4'b0000});
    num_a = (CW+2)'(y_pos) - (CW+2)'(va.y);
    num_b = (CW+2)'(y_pos) - (CW+2)'(vb.y);

    lx = (ax > bx) ? bx : ax;
    lz = (ax > bx) ? bz : az;
    rx = (ax > bx) ? ax : bx;
    rz = (ax > bx) ? az : bz;
    width    = (VW+1)'(rx) - (VW+1)'(lx);
    lx_ceil  = ((VW+1)'(lx) + (VW+1)'(15)) >>> 4;
    rx_floor = (VW+1)'(rx) >>> 4;
    c0_c     = (lx_ceil < 0) ? '0 : RW'(lx_ceil);
    c1_c     = (rx_floor > (VW+1)'(COL_LAST)) ? COL_LAST : RW'(rx_floor);

    x_pos = (VW+1)'({col, 4'b0000});
    num_x = x_pos - (VW+1)'(ax);

    if (lerp_res < 0) pz = '0;
    else if (lerp_res > zext(DEPTH_MAX)) pz = DEPTH_MAX;
    else pz = lerp_res[ZW-1:0];
    pz_less = (pz < depth_q);

    pix_wide = 21'(pixel_index);
    pix_addr = pix_wide[AW-1:0];
  end

  always_comb begin
    req.a   = VW'(va.x);
    req.b   = VW'(vc.x);
    req.num = num_a[NW-1:0];
    req.den = d_tot;
    case (step)
      2'd0: begin
        req.a = VW'(va.x);
        req.b = VW'(vc.x);
      end
      2'd1: begin
        req.a = zext(va.z);
        req.b = zext(vc.z);
      end
      2'd2: begin
        req.a   = half ? VW'(vb.x) : VW'(va.x);
        req.b   = half ? VW'(vc.x) : VW'(vb.x);
        req.num = half ? num_b[NW-1:0] : num_a[NW-1:0];
        req.den = half ? d_lo : d_up;
      end
      2'd3: begin
        req.a   = half ? zext(vb.z) : zext(va.z);
        req.b   = half ? zext(vc.z) : zext(vb.z);
        req.num = half ? num_b[NW-1:0] : num_a[NW-1:0];
        req.den = half ? d_lo : d_up;
      end
      default: ;
    endcase
    if (state == S_PIX_START) begin
      req.a   = az;
      req.b   = bz;
      req.num = num_x[NW-1:0];
      req.den = w;
    end
  end

  assign lerp_start = (state == S_L_START) || (state == S_PIX_START);

  zbtr_lerp u_lerp (
    .clk    (clk),
    .rst    (rst),
    .start  (lerp_start),
    .req    (req),
    .busy   (lerp_busy),
    .done   (lerp_done),
    .result (lerp_res)
  );

  always_comb begin
    mem_we    = (state == S_CLEAR) || ((state == S_PIX_WAIT) && lerp_done && pz_less);
    mem_color = (state == S_CLEAR) ? bg_color : color;
    mem_depth = (state == S_CLEAR) ? clear_depth : pz;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      color_mem[addr] <= mem_color;
      depth_mem[addr] <= mem_depth;
    end
    color_q <= color_mem[addr];
    depth_q <= depth_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      bg_color    <= '0;
      clear_depth <= DEPTH_MAX;
    end else begin
      if (state == S_FINISH && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_BG_COLOR: bg_color <= cfg_data;
          REG_CLEAR_DEPTH: clear_depth <= cfg_data[ZW-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_color <= '0;
            res_depth <= '0;
            cnt       <= '0;
            va        <= s1a;
            vb        <= s2b;
            vc        <= s2c;
            color     <= fill_color;
            case (kind)
              KIND_DRAW: state <= S_SETUP;
              KIND_CLEAR: begin
                addr  <= '0;
                state <= S_CLEAR;
              end
              KIND_READ: begin
                addr  <= pix_addr;
                state <= (pix_wide < 21'(PC)) ? S_RD_A : S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_CLEAR: begin
          addr <= addr + AW'(1);
          if (addr == ADDR_LAST) state <= S_FINISH;
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          res_color <= color_q;
          res_depth <= depth_q;
          state     <= S_FINISH;
        end
        S_SETUP: begin
          d_tot    <= tot[NW-1:0];
          d_up     <= NW'((CW+1)'(vb.y) - (CW+1)'(va.y));
          d_lo     <= NW'((CW+1)'(vc.y) - (CW+1)'(vb.y));
          r1       <= r1_c;
          lim_lo   <= lo_lim;
          lower_en <= (vc.y > vb.y);
          if (tot <= 0) begin
            state <= S_FINISH;
          end else if (vb.y > va.y) begin
            half  <= 1'b0;
            row   <= r0;
            lim   <= up_lim;
            state <= S_ROW_CHK;
          end else begin
            half  <= 1'b1;
            row   <= lo_lim;
            lim   <= r1_c;
            state <= S_ROW_CHK;
          end
        end
        S_ROW_CHK: begin
          if (row > lim) begin
            if (!half && lower_en) begin
              half <= 1'b1;
              row  <= lim_lo;
              lim  <= r1;
            end else begin
              state <= S_FINISH;
            end
          end else begin
            step  <= '0;
            state <= S_L_START;
          end
        end
        S_L_START: state <= S_L_WAIT;
        S_L_WAIT: begin
          if (lerp_done) begin
            case (step)
              2'd0: ax <= lerp_res;
              2'd1: az <= lerp_res;
              2'd2: bx <= lerp_res;
              2'd3: bz <= lerp_res;
              default: ;
            endcase
            step  <= step + 2'd1;
            state <= (step == 2'd3) ? S_ROW_FIX : S_L_START;
          end
        end
        S_ROW_FIX: begin
          ax <= lx;
          az <= lz;
          bx <= rx;
          bz <= rz;
          w  <= width[NW-1:0];
          col <= c0_c;
          c1  <= c1_c;
          if (width <= 0) begin
            row   <= row + RW'(1);
            state <= S_ROW_CHK;
          end else begin
            state <= S_COL_CHK;
          end
        end
        S_COL_CHK: begin
          if (col > c1) begin
            row   <= row + RW'(1);
            state <= S_ROW_CHK;
          end else begin
            addr  <= AW'(row[RB-1:0]) * ROW_PITCH + AW'(col[CB-1:0]);
            state <= S_PIX_START;
          end
        end
        S_PIX_START: state <= S_PIX_WAIT;
        S_PIX_WAIT: begin
          if (lerp_done) begin
            if (pz_less && cnt != COUNT_MAX) cnt <= cnt + KW'(1);
            col   <= col + RW'(1);
            state <= S_COL_CHK;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            read_color     <= res_color;
            read_depth     <= res_depth;
            pixels_written <= cnt;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_start_free: assert property (@(posedge clk) disable iff (rst)
    lerp_start |-> !lerp_busy)
    else $error("interpolation started while unit busy");
  a_depth_test: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == S_PIX_WAIT) |-> (pz < depth_q))
    else $error("pixel written without passing depth test");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && $past(state) != S_IDLE && !$past(rst)) |-> (cnt >= $past(cnt)))
    else $error("pixel count decreased during item");

endmodule

// ===== tb/tb_zbuffer_triangle_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zbuffer_triangle_rasterizer
// Self-checking bench for the z-buffer triangle rasterizer. A scoreboard keeps
// its own color and depth stores, works out the result of every accepted item
// and compares each result item field by field in order. Directed triangles,
// clears and reads come first, then random items under changing back-pressure.
// ----------------------------------------------------------------------------
module tb_zbuffer_triangle_rasterizer;
  import zbtr_pkg::*;

  localparam int W = 64;
  localparam int H = 64;
  localparam int NPIX = W * H;

  typedef struct {
    logic [31:0]   color;
    logic [ZW-1:0] depth;
    logic [KW-1:0] count;
  } res_t;

  typedef struct {
    logic [1:0]           kind;
    logic signed [CW-1:0] x[3];
    logic signed [CW-1:0] y[3];
    logic [ZW-1:0]        z[3];
    logic [31:0]          color;
    logic [11:0]          pix;
  } item_t;

  class raster_scoreboard;
    logic [31:0]   color_mem[NPIX];
    logic [ZW-1:0] depth_mem[NPIX];
    logic [31:0]   clr_color;
    logic [ZW-1:0] clr_depth;
    int            count;
    int            errors;
    int            checked;
    res_t          pending[$];

    function new();
      clr_color = 0;
      clr_depth = DEPTH_MAX;
      errors = 0;
      checked = 0;
    endfunction

    function longint fdiv(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
    endfunction

    function void span(longint r, longint ax, longint az, longint bx, longint bz,
                       logic [31:0] col);
      longint t, c, c0, c1, w, zz;
      int idx;
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = az; az = bz; bz = t;
      end
      w = bx - ax;
      if (w <= 0) return;
      c0 = -fdiv(-ax, 16);
      if (c0 < 0) c0 = 0;
      c1 = fdiv(bx, 16);
      if (c1 > W - 1) c1 = W - 1;
      for (c = c0; c <= c1; c++) begin
        zz = az + fdiv((bz - az) * (c * 16 - ax), w);
        if (zz < 0) zz = 0;
        if (zz > longint'(DEPTH_MAX)) zz = DEPTH_MAX;
        idx = int'(r * W + c);
        if (zz < longint'(depth_mem[idx])) begin
          depth_mem[idx] = ZW'(zz);
          color_mem[idx] = col;
          if (count < COUNT_MAX) count++;
        end
      end
    endfunction

    function void draw(item_t it);
      longint vx[3], vy[3], vz[3], t;
      longint tot, r, r0, r1, lim, yy;
      int i, j;
      int pa[3], pb[3];
      for (i = 0; i < 3; i++) begin
        vx[i] = it.x[i]; vy[i] = it.y[i]; vz[i] = it.z[i];
      end
      pa = '{0, 0, 1};
      pb = '{1, 2, 2};
      for (j = 0; j < 3; j++) begin
        if (vy[pa[j]] > vy[pb[j]]) begin
          t = vx[pa[j]]; vx[pa[j]] = vx[pb[j]]; vx[pb[j]] = t;
          t = vy[pa[j]]; vy[pa[j]] = vy[pb[j]]; vy[pb[j]] = t;
          t = vz[pa[j]]; vz[pa[j]] = vz[pb[j]]; vz[pb[j]] = t;
        end
      end
      tot = vy[2] - vy[0];
      if (tot <= 0) return;
      r0 = -fdiv(-vy[0], 16);
      if (r0 < 0) r0 = 0;
      r1 = fdiv(vy[2], 16);
      if (r1 > H - 1) r1 = H - 1;
      if (vy[1] > vy[0]) begin
        lim = fdiv(vy[1], 16);
        if (lim > r1) lim = r1;
        for (r = r0; r <= lim; r++) begin
          yy = r * 16;
          span(r, vx[0] + fdiv((vx[2] - vx[0]) * (yy - vy[0]), tot),
               vz[0] + fdiv((vz[2] - vz[0]) * (yy - vy[0]), tot),
               vx[0] + fdiv((vx[1] - vx[0]) * (yy - vy[0]), vy[1] - vy[0]),
               vz[0] + fdiv((vz[1] - vz[0]) * (yy - vy[0]), vy[1] - vy[0]), it.color);
        end
      end
      if (vy[2] > vy[1]) begin
        lim = -fdiv(-vy[1], 16);
        if (lim < r0) lim = r0;
        for (r = lim; r <= r1; r++) begin
          yy = r * 16;
          span(r, vx[0] + fdiv((vx[2] - vx[0]) * (yy - vy[0]), tot),
               vz[0] + fdiv((vz[2] - vz[0]) * (yy - vy[0]), tot),
               vx[1] + fdiv((vx[2] - vx[1]) * (yy - vy[1]), vy[2] - vy[1]),
               vz[1] + fdiv((vz[2] - vz[1]) * (yy - vy[1]), vy[2] - vy[1]), it.color);
        end
      end
    endfunction

    function void note_item(item_t it);
      res_t e;
      int i;
      e = '{0, 0, 0};
      case (it.kind)
        KIND_DRAW: begin
          count = 0;
          draw(it);
          e.count = KW'(count);
        end
        KIND_CLEAR: begin
          for (i = 0; i < NPIX; i++) begin
            color_mem[i] = clr_color;
            depth_mem[i] = clr_depth;
          end
        end
        KIND_READ: begin
          e.color = color_mem[it.pix];
          e.depth = depth_mem[it.pix];
        end
        default: ;
      endcase
      pending.push_back(e);
    endfunction

    function void check_result(res_t got);
      res_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result color %h depth %h count %0d", $time,
                 got.color, got.depth, got.count);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.color !== e.color) begin
        $display("%0t: read_color exp %h got %h", $time, e.color, got.color);
        errors++;
      end
      if (got.depth !== e.depth) begin
        $display("%0t: read_depth exp %h got %h", $time, e.depth, got.depth);
        errors++;
      end
      if (got.count !== e.count) begin
        $display("%0t: pixels_written exp %0d got %0d", $time, e.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [1:0] kind = 0;
  logic signed [CW-1:0] x1 = 0, y1 = 0, x2 = 0, y2 = 0, x3 = 0, y3 = 0;
  logic [ZW-1:0] z1 = 0, z2 = 0, z3 = 0;
  logic [31:0] fill_color = 0;
  logic [11:0] pixel_index = 0;
  logic [31:0] read_color;
  logic [ZW-1:0] read_depth;
  logic [KW-1:0] pixels_written;
  logic cfg_we = 0, cfg_index = 0;
  logic [31:0] cfg_data = 0;

  int send_idle = 12, recv_idle = 61;
  bit hold_off = 0;
  int accepted_in = 0, draws = 0, clears = 0, reads = 0;
  int quiet = 0;
  raster_scoreboard sb = new();

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  zbuffer_triangle_rasterizer dut (.*);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{read_color, read_depth, pixels_written});
    if (!rst) begin
      if (hold_off) out_ready <= 0;
      else out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 2000000) begin
      $display("watchdog expired");
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    kind <= it.kind;
    x1 <= it.x[0]; y1 <= it.y[0]; z1 <= it.z[0];
    x2 <= it.x[1]; y2 <= it.y[1]; z2 <= it.z[1];
    x3 <= it.x[2]; y3 <= it.y[2]; z3 <= it.z[2];
    fill_color <= it.color;
    pixel_index <= it.pix;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    accepted_in++;
    case (it.kind)
      KIND_DRAW: draws++;
      KIND_CLEAR: clears++;
      KIND_READ: reads++;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    if (idx == REG_BG_COLOR) sb.clr_color = val;
    else sb.clr_depth = val[ZW-1:0];
  endtask

  function automatic item_t tri_item(int ax, int ay, int az, int bx, int by, int bz,
                                     int cx, int cy, int cz, logic [31:0] col);
    item_t it;
    it.kind = KIND_DRAW;
    it.x = '{ax, bx, cx};
    it.y = '{ay, by, cy};
    it.z = '{az, bz, cz};
    it.color = col;
    it.pix = $urandom;
    return it;
  endfunction

  function automatic item_t op_item(logic [1:0] k, int p);
    item_t it;
    it = tri_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    it.kind = k;
    it.pix = p;
    return it;
  endfunction

  function automatic item_t rand_item();
    int sel, sz;
    item_t it;
    sel = $urandom_range(99);
    if (sel < 55) begin
      // mostly small triangles near the canvas, some huge or far off
      sz = ($urandom_range(9) == 0) ? 1400 : 200;
      it = tri_item($urandom_range(sz + 100) - 100, $urandom_range(sz + 100) - 100,
                    $urandom_range(24'hFFFFFF), $urandom_range(sz + 100) - 100,
                    $urandom_range(sz + 100) - 100, $urandom_range(24'hFFFFFF),
                    $urandom_range(sz + 100) - 100, $urandom_range(sz + 100) - 100,
                    $urandom_range(24'hFFFFFF), $urandom);
      if ($urandom_range(15) == 0)
        it = tri_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
    end else if (sel < 60) it = op_item(KIND_CLEAR, 0);
    else if (sel < 95) it = op_item(KIND_READ, $urandom_range(4095));
    else it = op_item(2'd3, $urandom);
    return it;
  endfunction

  initial begin
    item_t it;
    int i, ph;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    set_reg(REG_BG_COLOR, 32'hFFFF_FFFF);
    set_reg(REG_CLEAR_DEPTH, 24'h000000);
    send(op_item(KIND_CLEAR, 0));
    send(tri_item(0, 0, 0, 320, 0, 0, 0, 320, 0, 32'h1111_1111));
    send(op_item(KIND_READ, 0));
    drain();
    set_reg(REG_BG_COLOR, 32'h0);
    set_reg(REG_CLEAR_DEPTH, 24'hFFFFFF);
    send(op_item(KIND_CLEAR, 0));
    send(tri_item(0, 0, 100, 1008, 0, 200, 0, 1008, 24'hFFFFFF, 32'hA5A5_A5A5));
    send(tri_item(1008, 1008, 0, 1008, 0, 0, 0, 1008, 0, 32'h5A5A_5A5A));
    send(tri_item(-32768, -32768, 5, 32767, 0, 5, 0, 32767, 5, 32'hFFFF_FFFF));
    send(tri_item(40, 100, 50, 300, 100, 60, 200, 100, 70, 32'h1));
    send(tri_item(16, 16, 1000, 160, 160, 1000, 16, 160, 1000, 32'h2));
    send(tri_item(16, 16, 1000, 160, 160, 1000, 16, 160, 1000, 32'h3));
    send(tri_item(16, 160, 900, 160, 16, 900, 16, 16, 900, 32'h4));
    send(tri_item(80, 16, 1, 80, 500, 1, 80, 300, 1, 32'h5));
    send(tri_item(900, 200, 10, 1500, 400, 20, 1200, 800, 30, 32'h6));
    send(tri_item(-200, -200, 7, -100, 100, 7, 50, 60, 7, 32'h7));
    send(op_item(KIND_READ, 0));
    send(op_item(KIND_READ, 4095));
    send(op_item(KIND_READ, 2 * W + 3));
    send(op_item(2'd3, 12'hFFF));
    drain();

    set_reg(REG_BG_COLOR, $urandom);
    set_reg(REG_CLEAR_DEPTH, $urandom_range(24'hFFFFFF));
    send(op_item(KIND_CLEAR, 0));
    for (ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle = 61; recv_idle = 12;
      end else if (ph == 2) begin
        send_idle = 0; recv_idle = 0;
      end
      for (i = 0; i < 40; i++) begin
        if (ph == 0 && i == 20) begin
          fork
            begin
              hold_off = 1;
              repeat (20000) @(posedge clk);
              hold_off = 0;
            end
          join_none
        end
        it = rand_item();
        send(it);
      end
      drain();
      set_reg(REG_BG_COLOR, $urandom);
      set_reg(REG_CLEAR_DEPTH, (ph == 1) ? 24'hFFFFFF : $urandom_range(24'hFFFFFF));
    end
    drain();
    repeat (50) @(posedge clk);
    $display("%0d items in (%0d draws, %0d clears, %0d reads), %0d results checked",
             accepted_in, draws, clears, reads, sb.checked);
    $display("clear registers reprogrammed between phases under three stall mixes");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
